### design/sasq_pkg.sv
// ----------------------------------------------------------------------------
// sasq_pkg: shared definitions for the shifting array queue
// Operation codes, status codes, default depth and the control word that
// the top level broadcasts to every cell of the chain.
// ----------------------------------------------------------------------------
package sasq_pkg;

  // Default number of slots.
  localparam int DEPTH_DEF = 64;

  // Field widths fixed by the interface.
  localparam int MODE_W = 2;
  localparam int DATA_W = 32;
  localparam int STAT_W = 2;
  localparam int POS_W  = 6;
  localparam int OCC_W  = 7;

  // Operation codes.
  localparam logic [MODE_W-1:0] MODE_ENQ  = 2'd0;
  localparam logic [MODE_W-1:0] MODE_DEQ  = 2'd1;
  localparam logic [MODE_W-1:0] MODE_SRCH = 2'd2;

  // Status codes.
  localparam logic [STAT_W-1:0] ST_OK   = 2'd0;
  localparam logic [STAT_W-1:0] ST_FULL = 2'd1;
  localparam logic [STAT_W-1:0] ST_MISS = 2'd2;

  // Control word broadcast to every cell.
  typedef struct packed {
    logic              enq;   // write the word into the first empty cell
    logic              deq;   // shift every cell one place toward the head
    logic              kill;  // drop the search token wherever it is
    logic [DATA_W-1:0] key;   // enqueue word or search key
  } cell_ctrl_t;

endpackage

### design/shifting_array_queue_with_search.sv
// Enqueue, dequeue and unused-mode words: the result is registered, and a
// new word may start in every cycle (busy stays low).
// Search of a nonzero key: a token walks the cell chain one slot per cycle,
// so the result comes once it reaches slot p for a hit, or the last of the n
// queued words for a miss; busy is high meanwhile. A zero key or an empty
// queue answers without a scan. Synchronous reset empties every slot.
// ----------------------------------------------------------------------------
// shifting_array_queue_with_search: queue in a chain of shifting cells
// Slots hold a compacted queue where zero marks an empty slot; supports
// enqueue, dequeue and search for the lowest slot holding a key.
// ----------------------------------------------------------------------------
module shifting_array_queue_with_search #(
  parameter int DEPTH = sasq_pkg::DEPTH_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                start,
  output logic                                busy,
  input  logic [sasq_pkg::MODE_W-1:0]         in_mode,
  input  logic signed [sasq_pkg::DATA_W-1:0]  in_value,
  output logic                                out_valid,
  output logic [sasq_pkg::STAT_W-1:0]         out_status,
  output logic [sasq_pkg::POS_W-1:0]          out_position,
  output logic [sasq_pkg::OCC_W-1:0]          out_occupancy
);

  localparam int IW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

  typedef enum logic {S_IDLE, S_SCAN} state_t;

  state_t                      state_r;
  logic [CW-1:0]               count_r, count_nxt;
  logic [IW-1:0]               idx_r;
  logic [sasq_pkg::DATA_W-1:0] key_r;
  logic                        out_valid_r;
  logic [sasq_pkg::STAT_W-1:0] out_status_r;
  logic [IW-1:0]               out_pos_r;
  logic [CW-1:0]               out_occ_r;

  logic                        accept, full, launch, scan_last, scan_hit;
  sasq_pkg::cell_ctrl_t        ctrl;
  logic [sasq_pkg::DATA_W-1:0] slot_vec [DEPTH];
  logic [DEPTH-1:0]            used_vec, tok_vec, hit_vec;
  logic [31:0]                 pos_ext, occ_ext;

  assign accept    = start && (state_r == S_IDLE);
  assign full      = (count_r == FULL_CNT);
  assign scan_hit  = |hit_vec;
  assign scan_last = (count_r == (CW'(idx_r) + CW'(1)));

  // Search token enters the head cell for a nonzero key on a nonempty queue.
  assign launch = accept && (in_mode == sasq_pkg::MODE_SRCH) &&
                  (in_value != '0) && (count_r != '0);

  // Control word for the cells.
  always_comb begin
    ctrl.enq  = accept && (in_mode == sasq_pkg::MODE_ENQ) && !full;
    ctrl.deq  = accept && (in_mode == sasq_pkg::MODE_DEQ) && (count_r != '0);
    ctrl.kill = (state_r == S_SCAN) && (scan_hit || scan_last);
    ctrl.key  = (state_r == S_SCAN) ? key_r : in_value;
  end

  // Occupancy after the current word.
  always_comb begin
    count_nxt = count_r;
    if (ctrl.enq && (in_value != '0)) begin
      count_nxt = count_r + CW'(1);
    end else if (ctrl.deq) begin
      count_nxt = count_r - CW'(1);
    end
  end

  // Cell chain: head neighbor counts as occupied, tail neighbor feeds zero.
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic                        p_used, p_tok;
    logic [sasq_pkg::DATA_W-1:0] n_slot;
    if (i == 0) begin : g_head
      assign p_used = 1'b1;
      assign p_tok  = launch;
    end else begin : g_body
      assign p_used = used_vec[i-1];
      assign p_tok  = tok_vec[i-1];
    end
    if (i == DEPTH - 1) begin : g_tail
      assign n_slot = '0;
    end else begin : g_link
      assign n_slot = slot_vec[i+1];
    end
    sasq_cell u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .ctrl      (ctrl),
      .prev_used (p_used),
      .prev_tok  (p_tok),
      .next_slot (n_slot),
      .slot      (slot_vec[i]),
      .used      (used_vec[i]),
      .tok       (tok_vec[i]),
      .hit       (hit_vec[i])
    );
  end

  // Sequencer: state, count, scan index and the result register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      idx_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= 1'b0;
      count_r     <= count_nxt;
      unique case (state_r)
        S_IDLE: begin
          if (accept) begin
            out_occ_r <= count_nxt;
            out_pos_r <= '0;
            if (in_mode == sasq_pkg::MODE_ENQ) begin
              out_valid_r  <= 1'b1;
              out_status_r <= full ? sasq_pkg::ST_FULL : sasq_pkg::ST_OK;
            end else if (in_mode == sasq_pkg::MODE_SRCH) begin
              if (in_value == '0) begin
                // A zero key matches the first empty slot.
                out_valid_r  <= 1'b1;
                out_status_r <= full ? sasq_pkg::ST_MISS : sasq_pkg::ST_OK;
                out_pos_r    <= full ? '0 : IW'(count_r);
              end else if (count_r == '0) begin
                out_valid_r  <= 1'b1;
                out_status_r <= sasq_pkg::ST_MISS;
              end else begin
                key_r   <= in_value;
                idx_r   <= '0;
                state_r <= S_SCAN;
              end
            end else begin
              out_valid_r  <= 1'b1;
              out_status_r <= sasq_pkg::ST_OK;
            end
          end
        end
        S_SCAN: begin
          out_occ_r <= count_r;
          if (scan_hit) begin
            out_valid_r  <= 1'b1;
            out_status_r <= sasq_pkg::ST_OK;
            out_pos_r    <= idx_r;
            state_r      <= S_IDLE;
          end else if (scan_last) begin
            out_valid_r  <= 1'b1;
            out_status_r <= sasq_pkg::ST_MISS;
            out_pos_r    <= '0;
            state_r      <= S_IDLE;
          end else begin
            idx_r <= idx_r + IW'(1);
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign pos_ext = 32'(out_pos_r);
  assign occ_ext = 32'(out_occ_r);

  assign busy          = (state_r == S_SCAN);
  assign out_valid     = out_valid_r;
  assign out_status    = out_status_r;
  assign out_position  = pos_ext[sasq_pkg::POS_W-1:0];
  assign out_occupancy = occ_ext[sasq_pkg::OCC_W-1:0];

`ifndef SYNTH
  // At most one cell holds the search token at a time.
  a_one_tok: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0(tok_vec)) else $error("more than one search token in the chain");

  // The token stays inside the occupied prefix.
  a_scan_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SCAN) |-> (CW'(idx_r) < count_r))
    else $error("search index beyond the queued words");

  // A scan ends with a result and the token gone.
  a_scan_done: assert property (@(posedge clk) disable iff (!rst_n)
    ctrl.kill |=> (out_valid_r && (state_r == S_IDLE) && (tok_vec == '0)))
    else $error("search ended without a clean result");

  // A full report only comes from a full queue.
  a_full_stat: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && (out_status_r == sasq_pkg::ST_FULL)) |-> full)
    else $error("full status with free slots");

  // The occupied prefix ends where the count says.
  a_prefix: assert property (@(posedge clk) disable iff (!rst_n)
    (count_r != '0) |-> used_vec[IW'(count_r - CW'(1))])
    else $error("last queued slot is empty");
`endif

endmodule

### design/sasq_cell.sv
// ----------------------------------------------------------------------------
// sasq_cell: one slot of the shifting queue
// Holds one word, takes its tail neighbor's word on a dequeue, fills itself
// when it is the first empty slot, and passes the search token toward the
// tail one place per cycle while comparing its word with the key.
// ----------------------------------------------------------------------------
module sasq_cell (
  input  logic                                clk,
  input  logic                                rst_n,
  input  sasq_pkg::cell_ctrl_t                ctrl,
  input  logic                                prev_used,
  input  logic                                prev_tok,
  input  logic [sasq_pkg::DATA_W-1:0]         next_slot,
  output logic [sasq_pkg::DATA_W-1:0]         slot,
  output logic                                used,
  output logic                                tok,
  output logic                                hit
);

  logic [sasq_pkg::DATA_W-1:0] slot_r, slot_nxt;
  logic                        tok_r, tok_nxt;

  assign used = (slot_r != '0);

  // The first empty slot is the one whose head neighbor is occupied.
  always_comb begin
    slot_nxt = slot_r;
    if (ctrl.deq) begin
      slot_nxt = next_slot;
    end else if (ctrl.enq && !used && prev_used) begin
      slot_nxt = ctrl.key;
    end
  end

  // The token moves one cell per cycle until the search ends.
  assign tok_nxt = prev_tok & ~ctrl.kill;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      slot_r <= '0;
      tok_r  <= 1'b0;
    end else begin
      slot_r <= slot_nxt;
      tok_r  <= tok_nxt;
    end
  end

  assign slot = slot_r;
  assign tok  = tok_r;
  assign hit  = tok_r && (slot_r == ctrl.key);

endmodule
